### rtl/gtn_pkg.sv
// gtn_pkg: shared constants for the gradient-to-normal pixel pipeline
// no dependencies
package gtn_pkg;

  // radicand word of the square root and number of root bits
  localparam int RAD_W    = 64;
  localparam int SQ_STEPS = 32;
  // working width for divisor, numerators and signed intermediate sums
  localparam int DEN_W    = 33;
  localparam int SUM_W    = 36;
  // top output code
  localparam logic [31:0] OUT_MAX = 32'd65535;

endpackage

### rtl/gradient_to_normal_pixel_unit.sv
// gradient_to_normal_pixel_unit: per-pixel normal from a gradient pair
// uses gtn_pkg for widths and the saturation code
//
// usage:
//   input channel  : in_valid / in_stall with grad_x, grad_y (signed words)
//   output channel : out_valid / out_stall with normal_z, normal_y, normal_x
//                    (unsigned Q2.OUT_FRAC_BITS, rounded, saturated at 65535)
//   a word moves when valid is high and stall is low at a rising edge
//
// throughput: one word per cycle while out_stall is low; no pixel depends on another
// stages: a capture register and a squaring register, one radicand
//   stage, one root bit per stage over 32 stages, one divisor stage, one
//   integer-bit stage and one quotient bit per stage over OUT_FRAC_BITS + 1
//   stages shared by three lanes, and one rounding stage that is the output
//   register
// stall: the whole pipeline freezes while a finished word waits at the
//   output; in_stall then follows out_stall, and nothing is lost or
//   repeated
// reset: rst (synchronous) clears every valid bit; the datapath is not
//   reset
module gradient_to_normal_pixel_unit #(
  parameter int GRAD_BITS     = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [GRAD_BITS-1:0] grad_x,
  input  logic signed [GRAD_BITS-1:0] grad_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 normal_z,
  output logic [15:0]                 normal_y,
  output logic [15:0]                 normal_x
);

  localparam int G      = GRAD_BITS;
  localparam int K      = 31 - GRAD_BITS;
  localparam int NSQ    = gtn_pkg::SQ_STEPS;
  localparam int NDV    = OUT_FRAC_BITS + 2;
  localparam int RW     = gtn_pkg::RAD_W;
  localparam int DW     = gtn_pkg::DEN_W;
  localparam int SW     = gtn_pkg::SUM_W;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 0: capture
  logic                vld0;
  logic signed [G-1:0] gx0, gy0;
  // stage 1: squares
  logic                vld1;
  logic signed [G-1:0] gx1, gy1;
  logic [2*G-1:0]      sqx1, sqy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
      vld1 <= vld0;
    end
    if (en) begin
      gx0  <= grad_x;
      gy0  <= grad_y;
      gx1  <= gx0;
      gy1  <= gy0;
      sqx1 <= (2*G)'(gx0 * gx0);
      sqy1 <= (2*G)'(gy0 * gy0);
    end
  end

  // square root, one result bit per stage
  logic                vsq [0:NSQ];
  logic signed [G-1:0] gxs [0:NSQ];
  logic signed [G-1:0] gys [0:NSQ];
  logic [RW-1:0]       rad [0:NSQ];
  logic [RW-1:0]       rt  [0:NSQ];
  logic [RW-1:0]       rad_next [0:NSQ-1];
  logic [RW-1:0]       rt_next  [0:NSQ-1];
  logic [2*G-1:0]      qsum;

  assign qsum = sqx1 + sqy1 + (2*G)'(1);

  always_comb begin
    for (int i = 0; i < NSQ; i++) begin
      if (rad[i] >= rt[i] + (RW'(1) << (2*(NSQ-1-i)))) begin
        rad_next[i] = rad[i] - (rt[i] + (RW'(1) << (2*(NSQ-1-i))));
        rt_next[i]  = (rt[i] >> 1) + (RW'(1) << (2*(NSQ-1-i)));
      end else begin
        rad_next[i] = rad[i];
        rt_next[i]  = rt[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NSQ; i++) vsq[i] <= 1'b0;
    end else if (en) begin
      vsq[0] <= vld1;
      for (int i = 0; i < NSQ; i++) vsq[i+1] <= vsq[i];
    end
    if (en) begin
      rad[0] <= RW'({qsum, {(2*K){1'b0}}});
      rt[0]  <= '0;
      gxs[0] <= gx1;
      gys[0] <= gy1;
      for (int i = 0; i < NSQ; i++) begin
        rad[i+1] <= rad_next[i];
        rt[i+1]  <= rt_next[i];
        gxs[i+1] <= gxs[i];
        gys[i+1] <= gys[i];
      end
    end
  end

  // divisor and numerators, all at scale 2^K
  logic signed [SW-1:0] s_w, one_w, gx_w, gy_w, den_w, nz_w, ny_w, nx_w;
  assign s_w   = SW'($signed({1'b0, rt[NSQ][31:0]}));
  assign one_w = SW'(1) <<< K;
  assign gx_w  = SW'(gxs[NSQ]) <<< K;
  assign gy_w  = SW'(gys[NSQ]) <<< K;
  assign den_w = (s_w <<< 1) - gx_w - gy_w + one_w;
  assign nz_w  = s_w + one_w;
  assign ny_w  = s_w - gy_w;
  assign nx_w  = s_w - gx_w;

  // restoring division, one quotient bit per stage, three lanes
  logic            vdv [0:NDV];
  logic [DW-1:0]   den [0:NDV];
  logic [DW-1:0]   rem [0:NDV][0:2];
  logic [NDV-1:0]  quo [0:NDV][0:2];
  logic [DW:0]     rem2 [0:NDV-1][0:2];

  // first stage takes the integer bit without a shift, as z can exceed one
  always_comb begin
    for (int j = 0; j < NDV; j++) begin
      for (int c = 0; c < 3; c++) begin
        if (j == 0) rem2[j][c] = {1'b0, rem[j][c]};
        else        rem2[j][c] = {rem[j][c], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NDV; j++) vdv[j] <= 1'b0;
    end else if (en) begin
      vdv[0] <= vsq[NSQ];
      for (int j = 0; j < NDV; j++) vdv[j+1] <= vdv[j];
    end
    if (en) begin
      den[0]    <= den_w[DW-1:0];
      rem[0][0] <= nz_w[DW-1:0];
      rem[0][1] <= ny_w[DW-1:0];
      rem[0][2] <= nx_w[DW-1:0];
      for (int c = 0; c < 3; c++) quo[0][c] <= '0;
      for (int j = 0; j < NDV; j++) begin
        den[j+1] <= den[j];
        for (int c = 0; c < 3; c++) begin
          if (rem2[j][c] >= {1'b0, den[j]}) begin
            rem[j+1][c] <= DW'(rem2[j][c] - {1'b0, den[j]});
            quo[j+1][c] <= {quo[j][c][NDV-2:0], 1'b1};
          end else begin
            rem[j+1][c] <= rem2[j][c][DW-1:0];
            quo[j+1][c] <= {quo[j][c][NDV-2:0], 1'b0};
          end
        end
      end
    end
  end

  // round half up and saturate
  logic [NDV:0] qr [0:2];
  logic [15:0]  qs [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qr[c] = ({1'b0, quo[NDV][c]} + (NDV+1)'(1)) >> 1;
      if (32'(qr[c]) > gtn_pkg::OUT_MAX) qs[c] = 16'(gtn_pkg::OUT_MAX);
      else                               qs[c] = 16'(qr[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vdv[NDV];
    end
    if (en) begin
      normal_z <= qs[0];
      normal_y <= qs[1];
      normal_x <= qs[2];
    end
  end

endmodule

### rtl/gtn_checker.sv
// gtn_checker: port-level checks for gradient_to_normal_pixel_unit
// bound to the top level below; no package dependency
module gtn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] normal_z,
  input logic [15:0] normal_y,
  input logic [15:0] normal_x
);

  // a waiting word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(normal_z) && $stable(normal_y) && $stable(normal_x))
    else $error("output word changed while stalled");

  // input is only held back by a stalled finished word
  a_in_stall: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting output word");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind gradient_to_normal_pixel_unit gtn_checker u_gtn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .normal_z  (normal_z),
  .normal_y  (normal_y),
  .normal_x  (normal_x)
);
